FILE: src/tts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tick task scheduler.
// No dependencies; compiled first.
package tts_pkg;

    // Default table size
    localparam int NUM_TASKS_DEF = 16;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int TAG_W    = 8;
    localparam int TIME_W   = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int PEND_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2,
        ST_NONE = 2'd3
    } status_e_t;

    // One slot of the task table as held in RAM
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pend;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic fin_done;
    } stat_t;

endpackage

FILE: src/tts_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: valid/ready plus one command item.
// Depends on tts_pkg.
interface tts_cmd_if;
    import tts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TAG_W-1:0]  task_tag;
    logic [TIME_W-1:0] first_delay;
    logic [TIME_W-1:0] repeat_period;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, cmd, task_tag, first_delay, repeat_period, slot_index,
                    input ready);
    modport sink   (input valid, cmd, task_tag, first_delay, repeat_period, slot_index,
                    output ready);
endinterface

FILE: src/tts_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready plus one result item.
// Depends on tts_pkg.
interface tts_rsp_if;
    import tts_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    tag_out;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, slot, tag_out, status, last, input ready);
    modport sink   (input valid, slot, tag_out, status, last, output ready);
endinterface

FILE: src/tick_task_scheduler.sv
`timescale 1ns / 1ps
// Tick task scheduler: a table of NUM_TASKS task slots kept in one RAM, walked by a
// sequencer one slot per cycle through the RAM's single read port while no dispatch
// result is held back by the response side. A tick or a dispatch walks every slot, an
// add stops at the lowest free slot and a delete skips the walk; the final result waits
// while the response side holds back the output register. One command is worked at a
// time; the next command transfers in as soon as the final result of the previous one
// sits in the output register. Dispatch returns one result per slot with pending runs,
// in slot order, with last set on the final one, or a single result when none has runs.
module tick_task_scheduler #(
    parameter int NUM_TASKS = tts_pkg::NUM_TASKS_DEF
) (
    input logic   clk,
    input logic   rst_n,
    tts_cmd_if.sink   task_cmd,
    tts_rsp_if.source task_rsp
);
    import tts_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    tts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (task_cmd.valid),
        .in_cmd   (task_cmd.cmd),
        .in_ready (task_cmd.ready),
        .ctl      (ctl),
        .stat     (stat)
    );

    tts_datapath #(
        .NUM_TASKS (NUM_TASKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (task_cmd.cmd),
        .task_tag      (task_cmd.task_tag),
        .first_delay   (task_cmd.first_delay),
        .repeat_period (task_cmd.repeat_period),
        .slot_index    (task_cmd.slot_index),
        .out_valid     (task_rsp.valid),
        .out_ready     (task_rsp.ready),
        .slot          (task_rsp.slot),
        .tag_out       (task_rsp.tag_out),
        .status        (task_rsp.status),
        .last          (task_rsp.last)
    );
endmodule

FILE: src/tts_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: src/tts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the scheduler: idle, slot walk, final result.
// Depends on tts_pkg.
module tts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [tts_pkg::CMD_W-1:0] in_cmd,
    output logic                  in_ready,
    output tts_pkg::ctl_t         ctl,
    input  tts_pkg::stat_t        stat
);
    import tts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd_e_t'(in_cmd) == CMD_DELETE) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.fin_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath
    assign in_ready   = (state_reg == S_IDLE);
    assign ctl.load   = in_valid && (state_reg == S_IDLE);
    assign ctl.scan   = (state_reg == S_SCAN);
    assign ctl.finish = (state_reg == S_FINISH);
endmodule

FILE: src/tts_datapath.sv
`timescale 1ns / 1ps
// Scheduler datapath: task table RAM, valid bits, slot counter,
// held add or dispatch result and output register. Depends on tts_pkg, tts_ram.
module tts_datapath #(
    parameter int NUM_TASKS = tts_pkg::NUM_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tts_pkg::ctl_t                ctl,
    output tts_pkg::stat_t               stat,
    input  logic [tts_pkg::CMD_W-1:0]    cmd,
    input  logic [tts_pkg::TAG_W-1:0]    task_tag,
    input  logic [tts_pkg::TIME_W-1:0]   first_delay,
    input  logic [tts_pkg::TIME_W-1:0]   repeat_period,
    input  logic [tts_pkg::SLOT_W-1:0]   slot_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tts_pkg::SLOT_W-1:0]   slot,
    output logic [tts_pkg::TAG_W-1:0]    tag_out,
    output logic [tts_pkg::STATUS_W-1:0] status,
    output logic                         last
);
    import tts_pkg::*;

    localparam int IW = $clog2(NUM_TASKS > 1 ? NUM_TASKS : 2);

    // Latched command item
    cmd_e_t            cmd_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] delay_reg;
    logic [TIME_W-1:0] period_reg;
    logic [SLOT_W-1:0] sidx_reg;

    logic [IW-1:0]        idx_reg, idx_next;
    logic [NUM_TASKS-1:0] valid_reg, valid_next;

    // Held result: found slot on add, previous ready slot on dispatch
    logic             hold_vld_reg, hold_vld_next;
    logic [IW-1:0]    hold_slot_reg, hold_slot_next;
    logic [TAG_W-1:0] hold_tag_reg, hold_tag_next;

    // Output register
    logic              out_vld_reg, out_vld_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    status_e_t         out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;

    // RAM port signals
    logic          we;
    entry_t        wdata, cur;
    logic [IW-1:0] raddr;

    logic cur_valid, idx_end, out_free, ready_run;
    logic stall, add_hit, advance, disp_take, bad_slot;

    tts_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (cur)
    );

    // Slot walk decisions
    assign cur_valid = valid_reg[idx_reg];
    assign idx_end   = (idx_reg == IW'(NUM_TASKS - 1));
    assign out_free  = !out_vld_reg || out_ready;
    assign ready_run = cur_valid && (cur.pend != '0);
    assign stall     = ctl.scan && (cmd_reg == CMD_DISPATCH) && ready_run
                       && hold_vld_reg && !out_free;
    assign add_hit   = ctl.scan && (cmd_reg == CMD_ADD) && !cur_valid;
    assign advance   = ctl.scan && !stall && !add_hit;
    assign disp_take = ctl.scan && (cmd_reg == CMD_DISPATCH) && ready_run && !stall;
    assign bad_slot  = ({1'b0, sidx_reg} >= (SLOT_W + 1)'(NUM_TASKS));

    assign stat.scan_done = add_hit || (advance && idx_end);
    assign stat.fin_done  = ctl.finish && out_free;

    // Read address: slot 0 on load, next slot on advance short of the last, else re-read
    always_comb
    begin
        if (ctl.load)
        begin
            raddr = '0;
        end
        else if (advance && !idx_end)
        begin
            raddr = idx_reg + 1'b1;
        end
        else
        begin
            raddr = idx_reg;
        end
    end

    assign idx_next = ctl.load ? '0 : raddr;

    // Table write-back
    always_comb
    begin
        we    = 1'b0;
        wdata = cur;
        unique case (cmd_reg)
            CMD_TICK:
            begin
                if (ctl.scan && cur_valid)
                begin
                    we = 1'b1;
                    if (cur.delay == '0)
                    begin
                        if (cur.pend != '1)
                        begin
                            wdata.pend = cur.pend + 1'b1;
                        end
                        if (cur.period != '0)
                        begin
                            wdata.delay = cur.period;
                        end
                    end
                    else
                    begin
                        wdata.delay = cur.delay - 1'b1;
                    end
                end
            end
            CMD_ADD:
            begin
                if (add_hit)
                begin
                    we           = 1'b1;
                    wdata.tag    = tag_reg;
                    wdata.delay  = delay_reg;
                    wdata.period = period_reg;
                    wdata.pend   = '0;
                end
            end
            CMD_DISPATCH:
            begin
                if (disp_take)
                begin
                    we         = 1'b1;
                    wdata.pend = cur.pend - 1'b1;
                end
            end
            CMD_DELETE:
            begin
                we = 1'b0;
            end
            default: we = 1'b0;
        endcase
    end

    // Valid bits and held result
    always_comb
    begin
        valid_next     = valid_reg;
        hold_vld_next  = hold_vld_reg;
        hold_slot_next = hold_slot_reg;
        hold_tag_next  = hold_tag_reg;
        if (ctl.load || stat.fin_done)
        begin
            hold_vld_next = 1'b0;
        end
        if (add_hit)
        begin
            valid_next[idx_reg] = 1'b1;
            hold_vld_next       = 1'b1;
            hold_slot_next      = idx_reg;
            hold_tag_next       = tag_reg;
        end
        if (disp_take)
        begin
            hold_vld_next  = 1'b1;
            hold_slot_next = idx_reg;
            hold_tag_next  = cur.tag;
            // one-shot task leaves the table once reported
            if (cur.period == '0)
            begin
                valid_next[idx_reg] = 1'b0;
            end
        end
        if (stat.fin_done && (cmd_reg == CMD_DELETE) && !bad_slot)
        begin
            valid_next[sidx_reg[IW-1:0]] = 1'b0;
        end
    end

    // Result selection: a middle dispatch result or the final one
    always_comb
    begin
        out_load        = 1'b0;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (disp_take && hold_vld_reg)
        begin
            out_load        = 1'b1;
            out_slot_next   = SLOT_W'(hold_slot_reg);
            out_tag_next    = hold_tag_reg;
            out_status_next = ST_OK;
            out_last_next   = 1'b0;
        end
        else if (stat.fin_done)
        begin
            out_load      = 1'b1;
            out_last_next = 1'b1;
            unique case (cmd_reg)
                CMD_TICK:
                begin
                    out_slot_next   = '0;
                    out_tag_next    = '0;
                    out_status_next = ST_OK;
                end
                CMD_DELETE:
                begin
                    out_slot_next   = sidx_reg;
                    out_tag_next    = '0;
                    out_status_next = bad_slot ? ST_BAD : ST_OK;
                end
                CMD_ADD, CMD_DISPATCH:
                begin
                    if (hold_vld_reg)
                    begin
                        out_slot_next   = SLOT_W'(hold_slot_reg);
                        out_tag_next    = hold_tag_reg;
                        out_status_next = ST_OK;
                    end
                    else
                    begin
                        out_slot_next   = '0;
                        out_tag_next    = '0;
                        out_status_next = (cmd_reg == CMD_ADD) ? ST_FULL : ST_NONE;
                    end
                end
                default:
                begin
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    assign out_vld_next = out_load ? 1'b1 : (out_vld_reg && !out_ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            valid_reg    <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd_e_t'(cmd);
            tag_reg    <= task_tag;
            delay_reg  <= first_delay;
            period_reg <= repeat_period;
            sidx_reg   <= slot_index;
        end
        hold_slot_reg  <= hold_slot_next;
        hold_tag_reg   <= hold_tag_next;
        out_slot_reg   <= out_slot_next;
        out_tag_reg    <= out_tag_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_vld_reg;
    assign slot      = out_slot_reg;
    assign tag_out   = out_tag_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;
endmodule

FILE: src/tts_checker.sv
`timescale 1ns / 1ps
// Port-level checks for tick_task_scheduler, attached by bind.
// Depends on tts_pkg and tick_task_scheduler.
module tts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [tts_pkg::SLOT_W-1:0]   rsp_slot,
    input logic [tts_pkg::TAG_W-1:0]    rsp_tag_out,
    input logic [tts_pkg::STATUS_W-1:0] rsp_status,
    input logic                         rsp_last
);
    import tts_pkg::*;

    // Commands transferred in whose final result has not transferred out
    logic [1:0] open_reg, open_next;
    logic       in_xfer, out_done;

    assign in_xfer  = cmd_valid && cmd_ready;
    assign out_done = rsp_valid && rsp_ready && rsp_last;

    always_comb
    begin
        open_next = open_reg;
        if (in_xfer && !out_done)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (!in_xfer && out_done)
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // No result without an open command
    a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (open_reg != 2'd0))
        else $error("result shown with no open command");

    // At most one command worked while another's final result waits
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg == 2'd2) |-> !cmd_ready)
        else $error("command taken while two are open");

    // Error and empty results are always single
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NONE
                       || rsp_status == ST_BAD)) |-> rsp_last)
        else $error("error result without last");

    // Empty dispatch and full table report slot and tag zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_NONE || rsp_status == ST_FULL))
        |-> (rsp_slot == '0 && rsp_tag_out == '0))
        else $error("empty or full result carries a slot or tag");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_slot)
                                       && $stable(rsp_tag_out) && $stable(rsp_status)
                                       && $stable(rsp_last)))
        else $error("stalled result changed");
endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (task_cmd.valid),
    .cmd_ready   (task_cmd.ready),
    .rsp_valid   (task_rsp.valid),
    .rsp_ready   (task_rsp.ready),
    .rsp_slot    (task_rsp.slot),
    .rsp_tag_out (task_rsp.tag_out),
    .rsp_status  (task_rsp.status),
    .rsp_last    (task_rsp.last)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for tick_task_scheduler: directed and random command streams, checked against
// a task-table predictor kept in this file, with random idling on both channels.
// Depends on tts_pkg, tts_cmd_if, tts_rsp_if and tick_task_scheduler.
module tb_top;
    import tts_pkg::*;

    localparam int NT          = NUM_TASKS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_CMDS = 250;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        status_e_t         status;
        logic              last;
    } sched_result_t;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   mismatch_count;
    int   cmds_seen[4];
    int   status_seen[4];

    // Predicted task table
    logic              task_live   [NT];
    logic [TAG_W-1:0]  task_tag    [NT];
    logic [TIME_W-1:0] task_wait   [NT];
    logic [TIME_W-1:0] task_period [NT];
    logic [PEND_W-1:0] task_runs   [NT];

    sched_result_t results_due[$];

    tts_cmd_if cmd_if ();
    tts_rsp_if rsp_if ();

    tick_task_scheduler #(
        .NUM_TASKS (NT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .task_cmd (cmd_if),
        .task_rsp (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Task table predictor
    // ------------------------------------------------------------------
    function automatic void push_result(int slot, logic [TAG_W-1:0] tag, status_e_t st,
                                        logic last);
        sched_result_t r;
        r.slot   = slot[SLOT_W-1:0];
        r.tag    = tag;
        r.status = st;
        r.last   = last;
        results_due.push_back(r);
    endfunction

    function automatic void free_slot(int i);
        task_live[i]   = 1'b0;
        task_tag[i]    = '0;
        task_wait[i]   = '0;
        task_period[i] = '0;
        task_runs[i]   = '0;
    endfunction

    function automatic void predict_command(cmd_e_t op, logic [TAG_W-1:0] tag,
                                            logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per,
                                            logic [SLOT_W-1:0] idx);
        int  last_ready;
        bit  placed;
        last_ready = -1;
        placed     = 1'b0;
        cmds_seen[op]++;
        case (op)
            CMD_TICK:
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (task_live[i])
                    begin
                        if (task_wait[i] == '0)
                        begin
                            // count a run (saturating), reload unless one-shot
                            if (task_runs[i] != '1)
                                task_runs[i]++;
                            if (task_period[i] != '0)
                                task_wait[i] = task_period[i];
                        end
                        else
                            task_wait[i]--;
                    end
                end
                push_result(0, '0, ST_OK, 1'b1);
            end
            CMD_ADD:
            begin
                for (int i = 0; i < NT && !placed; i++)
                begin
                    if (!task_live[i])
                    begin
                        task_live[i]   = 1'b1;
                        task_tag[i]    = tag;
                        task_wait[i]   = dly;
                        task_period[i] = per;
                        task_runs[i]   = '0;
                        placed         = 1'b1;
                        push_result(i, tag, ST_OK, 1'b1);
                    end
                end
                if (!placed)
                    push_result(0, '0, ST_FULL, 1'b1);
            end
            CMD_DELETE:
            begin
                if (idx >= NT)
                    push_result(idx, '0, ST_BAD, 1'b1);
                else
                begin
                    free_slot(idx);
                    push_result(idx, '0, ST_OK, 1'b1);
                end
            end
            default:
            begin
                // the final ready slot carries last
                for (int i = 0; i < NT; i++)
                    if (task_live[i] && task_runs[i] != '0)
                        last_ready = i;
                if (last_ready < 0)
                    push_result(0, '0, ST_NONE, 1'b1);
                else
                begin
                    for (int i = 0; i <= last_ready; i++)
                    begin
                        if (task_live[i] && task_runs[i] != '0)
                        begin
                            push_result(i, task_tag[i], ST_OK, i == last_ready);
                            task_runs[i]--;
                            if (task_period[i] == '0)
                                free_slot(i);
                        end
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_command(cmd_e_t op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] dly,
                                logic [TIME_W-1:0] per, logic [SLOT_W-1:0] idx);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.cmd           <= op;
        cmd_if.task_tag      <= tag;
        cmd_if.first_delay   <= dly;
        cmd_if.repeat_period <= per;
        cmd_if.slot_index    <= idx;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        predict_command(op, tag, dly, per, idx);
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, in-order compare
    // ------------------------------------------------------------------
    initial
    begin : check_results
        sched_result_t want;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                status_seen[rsp_if.status]++;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: slot %0d tag %0d status %0d last %0d",
                           rsp_if.slot, rsp_if.tag_out, rsp_if.status, rsp_if.last);
                    mismatch_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_if.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, rsp_if.slot);
                        mismatch_count++;
                    end
                    if (rsp_if.tag_out !== want.tag)
                    begin
                        $error("tag_out: expected %0d, got %0d", want.tag, rsp_if.tag_out);
                        mismatch_count++;
                    end
                    if (rsp_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                        mismatch_count++;
                    end
                end
            end
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    // Stall watchdog: too long without any transfer ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: nothing ready, out-of-range deletes
    task automatic test_empty_table();
        send_command(CMD_DISPATCH, '0, '0, '0, '0);
        send_command(CMD_DELETE, '0, '0, '0, 6'd63);
        send_command(CMD_DELETE, '1, '1, '1, 6'(NT));
    endtask

    // Fill every slot with due tasks, overflow, then one dispatch covering all slots
    task automatic test_fill_and_dispatch();
        for (int i = 0; i < NT; i++)
            send_command(CMD_ADD, (i == 0) ? 8'hFF : 8'(i * 17), '0,
                         (i % 2) ? 16'hFFFF : 16'h0000, '0);
        send_command(CMD_ADD, 8'h5A, 16'h0001, 16'h0001, '0);
        send_command(CMD_TICK, '0, '0, '0, '0);
        send_command(CMD_DISPATCH, '0, '0, '0, '0);
    endtask

    // Largest times, delete of a live slot and of a free one, slot reuse
    task automatic test_edge_fields();
        send_command(CMD_ADD, 8'hA5, 16'hFFFF, 16'hFFFF, '0);
        send_command(CMD_DELETE, '0, '0, '0, 6'd1);
        send_command(CMD_DELETE, '0, '0, '0, 6'd2);
        send_command(CMD_DELETE, '0, '0, '0, 6'(NT - 1));
        send_command(CMD_ADD, 8'h00, 16'h0000, 16'h0001, '0);
    endtask

    // Runs pile up: a one-shot task gains a run every tick, a period-1 task every second
    // tick; the one-shot task leaves at its first dispatch, the rest drain until nothing is ready
    task automatic test_run_backlog();
        no_idle = 1'b1;
        for (int i = 0; i < NT; i++)
            send_command(CMD_DELETE, '0, '0, '0, 6'(i));
        send_command(CMD_ADD, 8'hC3, 16'h0000, 16'h0000, '0);
        send_command(CMD_ADD, 8'h3C, 16'h0000, 16'h0001, '0);
        repeat (20)
            send_command(CMD_TICK, '0, '0, '0, '0);
        repeat (11)
            send_command(CMD_DISPATCH, '0, '0, '0, '0);
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Random mix, weighted toward short delays and periods so tasks fire often
    task automatic test_random_mix();
        cmd_e_t            op;
        int                pick;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] per;
        logic [SLOT_W-1:0] idx;
        repeat (RANDOM_CMDS)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = CMD_TICK;
            else if (pick < 65)
                op = CMD_ADD;
            else if (pick < 77)
                op = CMD_DELETE;
            else
                op = CMD_DISPATCH;
            dly = ($urandom_range(9) < 8) ? TIME_W'($urandom_range(3))
                                          : TIME_W'($urandom_range(16'hFFFF));
            pick = $urandom_range(99);
            if (pick < 30)
                per = '0;
            else if (pick < 85)
                per = TIME_W'($urandom_range(4, 1));
            else
                per = TIME_W'($urandom_range(16'hFFFF));
            idx = ($urandom_range(4) != 0) ? SLOT_W'($urandom_range(NT - 1))
                                           : SLOT_W'($urandom_range(63));
            send_command(op, TAG_W'($urandom_range(255)), dly, per, idx);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_if.valid         <= 1'b0;
        cmd_if.cmd           <= CMD_TICK;
        cmd_if.task_tag      <= '0;
        cmd_if.first_delay   <= '0;
        cmd_if.repeat_period <= '0;
        cmd_if.slot_index    <= '0;
        rst_n                <= 1'b0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        for (int i = 0; i < NT; i++)
            free_slot(i);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_fill_and_dispatch();
        test_edge_fields();
        wait_drained();
        test_run_backlog();
        test_random_mix();
        wait_drained();
        repeat (NT + 8) @(posedge clk);

        $display("commands: %0d tick, %0d add, %0d delete, %0d dispatch",
                 cmds_seen[CMD_TICK], cmds_seen[CMD_ADD], cmds_seen[CMD_DELETE],
                 cmds_seen[CMD_DISPATCH]);
        $display("results: %0d ok, %0d table full, %0d bad slot, %0d nothing ready",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD],
                 status_seen[ST_NONE]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
src/tts_pkg.sv
src/tts_cmd_if.sv
src/tts_rsp_if.sv
src/tts_ram.sv
src/tts_ctrl.sv
src/tts_datapath.sv
src/tick_task_scheduler.sv
src/tts_checker.sv
tb/tb_top.sv
